>>> sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication, disabled while reset is low
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// non-overlapping implication, consequent checked in the next cycle, disabled while reset is low
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/ose_pkg.sv
// types, constants and bit mapping for the oriented sprite expander
`timescale 1ns / 1ps

package ose_pkg;

  localparam int unsigned SpriteSide  = 8;
  localparam int unsigned CoordW      = $clog2(SpriteSide);
  localparam int unsigned CellW       = 2 * CoordW;
  localparam int unsigned SpriteBits  = SpriteSide * SpriteSide;
  localparam int unsigned PosW        = 12;
  localparam int unsigned RectPosW    = 13;
  localparam int unsigned ScaleW      = 4;
  localparam int unsigned ColorW      = 32;
  localparam int unsigned OffsetW     = CoordW + ScaleW;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_FLIP   = 2'd1,
    MODE_ROT90  = 2'd2,
    MODE_ROT270 = 2'd3
  } mode_e;

  typedef struct packed {
    logic [PosW-1:0]       pos_x;
    logic [PosW-1:0]       pos_y;
    logic [ScaleW-1:0]     scale;
    logic [ColorW-1:0]     fg_color;
    logic [ColorW-1:0]     clear_color;
    logic [SpriteBits-1:0] sprite;
    mode_e                 mode;
  } cmd_t;

  typedef struct packed {
    logic [RectPosW-1:0] rect_x;
    logic [RectPosW-1:0] rect_y;
    logic [ScaleW-1:0]   rect_side;
    logic [ColorW-1:0]   rect_color;
    logic                last;
  } rect_t;

  // sprite bit read for cell (cx,cy) under each orientation
  function automatic logic [CellW-1:0] bit_index(mode_e m, logic [CoordW-1:0] cx,
                                                  logic [CoordW-1:0] cy);
    logic [CellW-1:0] idx;
    case (m)
      MODE_NORMAL: idx = {~cy, ~cx};
      MODE_FLIP:   idx = {cy, cx};
      MODE_ROT90:  idx = {~cx, cy};
      MODE_ROT270: idx = {cx, ~cy};
      default:     idx = '0;
    endcase
    return idx;
  endfunction

endpackage

>>> sv/oriented_sprite_expander.sv
// oriented sprite expander: one sprite command in, 64 square fills out
`timescale 1ns / 1ps

// usage
// - input channel in_valid_i / in_ready_o carries one sprite command (cmd_t)
// - output channel out_valid_o / out_ready_i carries square-fill commands (rect_t),
//   64 per sprite, row-major with rows outer, last set on the 64th
// - the command transaction sets the busy flag; the first square then moves into the output register
// - throughput: one square per cycle while the receiver does not stall; the
//   cell counter that walks the 64 cells sets this rate
// - the next command is taken in the cycle the final cell moves into the
//   output register, so sprites run back to back with no gap
// - a stalled receiver holds the output register; the cell counter waits
//   and no square is lost or repeated
// - reset clears the busy flag, cell counter and output valid; the block
//   is ready for a command straight after reset
module oriented_sprite_expander (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ose_pkg::cmd_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ose_pkg::rect_t out_data_o
);

  ose_pkg::cmd_t               cmd_q;
  logic                        busy_q, busy_d;
  logic [ose_pkg::CellW-1:0]   cell_q, cell_d;
  ose_pkg::rect_t              out_q, out_d;
  logic                        out_valid_q, out_valid_d;

  logic                        advance;
  logic                        last_cell;
  logic                        in_take;
  logic [ose_pkg::CoordW-1:0]  cx, cy;
  logic [ose_pkg::CellW-1:0]   bit_idx;
  logic [ose_pkg::OffsetW-1:0] off_x, off_y;

  always_comb begin
    advance    = busy_q && (!out_valid_q || out_ready_i);
    last_cell  = (cell_q == '1);
    in_ready_o = !busy_q || (advance && last_cell);
    in_take    = in_valid_i && in_ready_o;

    cx      = cell_q[ose_pkg::CoordW-1:0];
    cy      = cell_q[ose_pkg::CellW-1:ose_pkg::CoordW];
    bit_idx = ose_pkg::bit_index(cmd_q.mode, cx, cy);

    off_x = ose_pkg::OffsetW'(cx) * ose_pkg::OffsetW'(cmd_q.scale);
    off_y = ose_pkg::OffsetW'(cy) * ose_pkg::OffsetW'(cmd_q.scale);

    out_d.rect_x     = ose_pkg::RectPosW'(cmd_q.pos_x) + ose_pkg::RectPosW'(off_x);
    out_d.rect_y     = ose_pkg::RectPosW'(cmd_q.pos_y) + ose_pkg::RectPosW'(off_y);
    out_d.rect_side  = cmd_q.scale;
    out_d.rect_color = cmd_q.sprite[bit_idx] ? cmd_q.fg_color : cmd_q.clear_color;
    out_d.last       = last_cell;

    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end

    // counter wraps back to zero after the final cell
    cell_d = advance ? cell_q + 1'b1 : cell_q;

    if (in_take) begin
      busy_d = 1'b1;
    end else if (advance && last_cell) begin
      busy_d = 1'b0;
    end else begin
      busy_d = busy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cell_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cell_q      <= cell_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/ose_checker.sv
// port-level checker for the oriented sprite expander and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ose_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input ose_pkg::rect_t out_data_o
);

  logic in_txn;
  logic out_stall;
  logic out_mid_txn;
  logic txn_p1_q, txn_p2_q;

  assign in_txn      = in_valid_i && in_ready_o;
  assign out_stall   = out_valid_o && !out_ready_i;
  assign out_mid_txn = out_valid_o && out_ready_i && !out_data_o.last;

  // command transaction delayed through txn_p1_q and txn_p2_q, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      txn_p1_q <= 1'b0;
      txn_p2_q <= 1'b0;
    end else begin
      txn_p1_q <= in_txn;
      txn_p2_q <= txn_p1_q;
    end
  end

  // a stalled square holds
  `ASSERT_NEXT_CYCLE(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_data_o))

  // squares of one sprite follow with no gap
  `ASSERT_NEXT_CYCLE(a_no_gap, clk_i, rst_ni, out_mid_txn, out_valid_o)

  // a square is on offer once the command transaction has passed through txn_p1_q and txn_p2_q
  `ASSERT_SAME_CYCLE(a_first_out, clk_i, rst_ni, txn_p2_q, out_valid_o)

endmodule

bind oriented_sprite_expander ose_checker u_ose_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> tb/tb_oriented_sprite_expander.sv
// testbench for the oriented sprite expander: directed and random sprites, squares checked
`timescale 1ns / 1ps

module tb_oriented_sprite_expander;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned LastCoord  = ose_pkg::SpriteSide - 1;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid;
  logic           in_ready;
  ose_pkg::cmd_t  in_data;
  logic           out_valid;
  logic           out_ready;
  ose_pkg::rect_t out_data;

  ose_pkg::rect_t pending_squares[$];
  int             mismatches;
  int             squares_seen;
  bit             steady;

  oriented_sprite_expander dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // 64 squares of one sprite, row-major with rows outer
  function automatic void expand_sprite(input ose_pkg::cmd_t c);
    int             idx;
    ose_pkg::rect_t sq;
    for (int cy = 0; cy < ose_pkg::SpriteSide; cy++) begin
      for (int cx = 0; cx < ose_pkg::SpriteSide; cx++) begin
        case (c.mode)
          ose_pkg::MODE_NORMAL: idx = (LastCoord - cy) * ose_pkg::SpriteSide + (LastCoord - cx);
          ose_pkg::MODE_FLIP:   idx = cy * ose_pkg::SpriteSide + cx;
          ose_pkg::MODE_ROT90:  idx = (LastCoord - cx) * ose_pkg::SpriteSide + cy;
          default:              idx = cx * ose_pkg::SpriteSide + (LastCoord - cy);
        endcase
        sq.rect_x     = ose_pkg::RectPosW'(int'(c.pos_x) + cx * int'(c.scale));
        sq.rect_y     = ose_pkg::RectPosW'(int'(c.pos_y) + cy * int'(c.scale));
        sq.rect_side  = c.scale;
        sq.rect_color = c.sprite[idx] ? c.fg_color : c.clear_color;
        sq.last       = (cy == LastCoord) && (cx == LastCoord);
        pending_squares.push_back(sq);
      end
    end
  endfunction

  function automatic ose_pkg::cmd_t make_cmd(input logic [ose_pkg::PosW-1:0] px,
                                             input logic [ose_pkg::PosW-1:0] py,
                                             input logic [ose_pkg::ScaleW-1:0] sc,
                                             input logic [ose_pkg::ColorW-1:0] fg,
                                             input logic [ose_pkg::ColorW-1:0] bg,
                                             input logic [ose_pkg::SpriteBits-1:0] spr,
                                             input ose_pkg::mode_e m);
    ose_pkg::cmd_t c;
    c.pos_x       = px;
    c.pos_y       = py;
    c.scale       = sc;
    c.fg_color    = fg;
    c.clear_color = bg;
    c.sprite      = spr;
    c.mode        = m;
    return c;
  endfunction

  function automatic logic [ose_pkg::PosW-1:0] random_pos();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return ose_pkg::PosW'($urandom);
    endcase
  endfunction

  function automatic ose_pkg::cmd_t random_cmd();
    return make_cmd(random_pos(), random_pos(), ose_pkg::ScaleW'($urandom_range(15)),
                    $urandom, $urandom, {$urandom, $urandom},
                    ose_pkg::mode_e'(2'($urandom_range(3))));
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("square %0d: %s is %0h, expected %0h", squares_seen, field, got, want);
    mismatches++;
  endtask

  // check each square against the oldest expectation, then record new sprites
  always @(posedge clk_i) begin
    ose_pkg::rect_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_squares.size() == 0) begin
        report_mismatch("unexpected square", 64'(out_data), 64'd0);
      end else begin
        want = pending_squares.pop_front();
        if (out_data.rect_x !== want.rect_x)
          report_mismatch("rect_x", 64'(out_data.rect_x), 64'(want.rect_x));
        if (out_data.rect_y !== want.rect_y)
          report_mismatch("rect_y", 64'(out_data.rect_y), 64'(want.rect_y));
        if (out_data.rect_side !== want.rect_side)
          report_mismatch("rect_side", 64'(out_data.rect_side), 64'(want.rect_side));
        if (out_data.rect_color !== want.rect_color)
          report_mismatch("rect_color", 64'(out_data.rect_color), 64'(want.rect_color));
        if (out_data.last !== want.last)
          report_mismatch("last", 64'(out_data.last), 64'(want.last));
      end
      squares_seen++;
    end
    if (rst_ni && in_valid && in_ready) begin
      expand_sprite(in_data);
    end
  end

  // receiver back-pressure
  initial begin
    out_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      out_ready <= steady || ($urandom_range(99) >= 19);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("oriented_sprite_expander test failed");
    $finish;
  end

  // returns in the step of the command transaction
  task automatic send_sprite(input ose_pkg::cmd_t c);
    while (!steady && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_squares.size() != 0);
  endtask

  task automatic test_field_extremes();
    send_sprite(make_cmd('0, '0, 4'd1, '0, '1, '0, ose_pkg::MODE_NORMAL));
    send_sprite(make_cmd('1, '1, 4'd15, '1, '0, '1, ose_pkg::MODE_FLIP));
    send_sprite(make_cmd('1, '0, 4'd15, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                         64'hAAAA_AAAA_AAAA_AAAA, ose_pkg::MODE_ROT90));
    send_sprite(make_cmd('0, '1, 4'd1, 32'h0000_0001, 32'h8000_0000,
                         64'h5555_5555_5555_5555, ose_pkg::MODE_ROT270));
  endtask

  // lone corner bits and an uneven pattern tell the four orientations apart
  task automatic test_orientations();
    for (int m = 0; m < 4; m++) begin
      send_sprite(make_cmd(12'd100, 12'd200, 4'd3, 32'h00FF_00FF, 32'h1234_5678,
                           64'h0000_0000_0000_0001, ose_pkg::mode_e'(2'(m))));
      send_sprite(make_cmd(12'd7, 12'd4000, 4'd9, 32'hDEAD_BEEF, 32'h0BAD_F00D,
                           64'h8000_0000_0000_0000, ose_pkg::mode_e'(2'(m))));
      send_sprite(make_cmd(12'd2048, 12'd1, 4'd5, 32'hCAFE_0001, 32'h0000_FACE,
                           64'h0123_4567_89AB_CDEF, ose_pkg::mode_e'(2'(m))));
    end
  endtask

  // zero scale still gives 64 squares, all on the sprite origin
  task automatic test_scale_zero();
    send_sprite(make_cmd(12'd321, 12'd654, 4'd0, 32'hFFFF_0000, 32'h0000_FFFF,
                         64'hF0E1_D2C3_B4A5_9687, ose_pkg::MODE_NORMAL));
    send_sprite(make_cmd('1, '1, 4'd0, 32'h1111_1111, 32'h2222_2222,
                         64'h0F0F_0F0F_F0F0_F0F0, ose_pkg::MODE_ROT90));
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    repeat (6) send_sprite(random_cmd());
    steady = 1'b0;
  endtask

  task automatic test_drain_pause();
    repeat (3) send_sprite(random_cmd());
    wait_drained();
    repeat (3) send_sprite(random_cmd());
  endtask

  task automatic test_random();
    repeat (470) send_sprite(random_cmd());
  endtask

  initial begin
    mismatches   = 0;
    squares_seen = 0;
    steady       = 1'b0;
    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_orientations();
    test_scale_zero();
    test_back_to_back();
    test_drain_pause();
    test_random();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("oriented_sprite_expander test passed");
    end else begin
      $display("oriented_sprite_expander test failed");
    end
    $finish;
  end

endmodule
